/* src/ptd_pkg.sv */
// Package for the periodic task dispatcher: entry, control and result types and codes.
`default_nettype none
package ptd_pkg;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_ENABLE = 3'd3;
  localparam logic [2:0] CMD_RUN    = 3'd4;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_REJECT   = 3'd1;
  localparam logic [2:0] ST_BADSLOT  = 3'd2;
  localparam logic [2:0] ST_DISPATCH = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  // Dispatches allowed in one scan
  localparam int MAX_RESULTS = 8;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] period;
    logic [31:0] next_run;
    logic        en;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic set_en;
    logic en_val;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [7:0]  tag;
    logic        last;
    logic [31:0] tick;
    logic [3:0]  count;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

endpackage
`default_nettype wire

/* src/periodic_task_dispatcher.sv */
// Top level of the periodic task dispatcher: command decode, scan sequencer and result register.
//
// Input channel (in_valid/in_ready) carries one command item: tick, add, remove,
// set enable or run scan. Output channel (out_valid/out_ready) carries result items.
// Tick, add, remove, set enable and unused codes give a single result, which is registered
// and shown the cycle after the item is accepted. A run scan rotates the whole
// chain of TABLE_DEPTH cells once through the head cell, one entry a cycle
// unless the scan stalls, then registers the closing result in the flush
// state. Each due task gives one result, up to MAX_RESULTS per scan, the last
// one marked by last; with nothing due a single none-due result is given.
// The rotation of the chain sets the scan length. A new item is taken only when
// the sequencer is idle and the result register is empty or being emptied.
// When the receiver stalls, the scan holds on a due entry while one dispatch is
// already waiting behind a full result register; results are never dropped.
// Reset clears every table entry, the task count and the tick counter at once.
`default_nettype none
module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [7:0]  task_tag,
  input  wire logic [31:0] period,
  input  wire logic [31:0] start_offset,
  input  wire logic [2:0]  slot,
  input  wire logic        enable_flag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [2:0]       out_slot,
  output logic [7:0]       out_tag,
  output logic             last,
  output logic [31:0]      tick_now,
  output logic [3:0]       count_now
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W = CNT_W + 3;

  entry_t     cells_q [TABLE_DEPTH];
  entry_t     nb_in   [TABLE_DEPTH];
  cell_ctrl_t ctrl    [TABLE_DEPTH];
  entry_t     load_data;
  entry_t     head_upd;
  entry_t     tail_in;
  logic       head_due;
  logic       head_active;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [3:0]       n_disp, n_disp_next;
  logic [CNT_W-1:0] count, count_next;
  logic [31:0]      tick, tick_next;
  result_t          out_res, out_res_next;
  logic             out_valid_next;
  result_t          pend, pend_next;
  logic             pend_valid, pend_valid_next;

  logic             accept;
  logic             out_free;
  logic             rotate;
  logic             stall;
  logic             slot_ok;
  logic             add_ok;
  logic [CMP_W-1:0] slot_w;
  logic [CMP_W-1:0] count_w;
  logic [IDX_W+2:0] idx_ext;
  logic [CNT_W+3:0] count_ext;
  result_t          res_single;
  result_t          res_disp;

  // Chain of cells; the tail is fed by the head during a scan, by zero on remove
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign nb_in[k] = tail_in;
    end else begin : g_mid
      assign nb_in[k] = cells_q[k+1];
    end

    always_comb begin
      ctrl[k].shift  = rotate ||
                       (accept && (cmd == CMD_REMOVE) && slot_ok &&
                        (CMP_W'(k) >= slot_w));
      ctrl[k].load   = accept && (cmd == CMD_ADD) && add_ok && (CMP_W'(k) == count_w);
      ctrl[k].set_en = accept && (cmd == CMD_ENABLE) && slot_ok && (CMP_W'(k) == slot_w);
      ctrl[k].en_val = enable_flag;
    end

    ptd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[k]),
      .load_data (load_data),
      .nb_in     (nb_in[k]),
      .q         (cells_q[k])
    );
  end

  ptd_head u_head (
    .head   (cells_q[0]),
    .tick   (tick),
    .active (head_active),
    .due    (head_due),
    .upd    (head_upd)
  );

  always_comb begin
    slot_w      = CMP_W'(slot);
    count_w     = CMP_W'(count);
    idx_ext     = {3'b000, idx};
    count_ext   = {4'b0000, count};
    slot_ok     = slot_w < count_w;
    add_ok      = (count_w < CMP_W'(TABLE_DEPTH)) && (task_tag != 8'd0);
    out_free    = !out_valid || out_ready;
    in_ready    = (state == S_IDLE) && out_free;
    accept      = in_valid && in_ready;
    head_active = (CNT_W'(idx) < count) && (n_disp < 4'(MAX_RESULTS));
    stall       = head_due && pend_valid && !out_free;
    rotate      = (state == S_SCAN) && !stall;
    tail_in     = (state == S_SCAN) ? head_upd : '0;

    load_data.tag      = task_tag;
    load_data.period   = period;
    load_data.next_run = tick + start_offset;
    load_data.en       = 1'b1;

    res_single        = '0;
    res_single.status = ST_DONE;
    res_single.last   = 1'b1;
    res_single.tick   = tick;
    res_single.count  = count_ext[3:0];
    count_next        = count;
    tick_next         = tick;

    unique case (cmd)
      CMD_TICK: begin
        if (accept) tick_next = tick + 32'd1;
        res_single.tick = tick + 32'd1;
      end
      CMD_ADD: begin
        if (add_ok) begin
          res_single.slot  = count_ext[2:0];
          res_single.count = 4'(count_ext + (CNT_W+4)'(1));
          if (accept) count_next = count + CNT_W'(1);
        end else begin
          res_single.status = ST_REJECT;
        end
      end
      CMD_REMOVE: begin
        if (slot_ok) begin
          res_single.count = 4'(count_ext - (CNT_W+4)'(1));
          if (accept) count_next = count - CNT_W'(1);
        end else begin
          res_single.status = ST_BADSLOT;
        end
      end
      CMD_ENABLE: begin
        if (!slot_ok) res_single.status = ST_BADSLOT;
      end
      default: begin
      end
    endcase

    res_disp        = '0;
    res_disp.status = ST_DISPATCH;
    res_disp.slot   = idx_ext[2:0];
    res_disp.tag    = cells_q[0].tag;
    res_disp.tick   = tick;
    res_disp.count  = count_ext[3:0];

    state_next      = state;
    idx_next        = idx;
    n_disp_next     = n_disp;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    out_res_next    = out_res;
    out_valid_next  = out_valid && !out_ready;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_RUN) begin
            state_next      = S_SCAN;
            idx_next        = '0;
            n_disp_next     = 4'd0;
            pend_valid_next = 1'b0;
          end else begin
            out_res_next   = res_single;
            out_valid_next = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (!stall) begin
          // Hold one dispatch back so the final one can carry last
          if (head_due) begin
            if (pend_valid) begin
              out_res_next   = pend;
              out_valid_next = 1'b1;
            end
            pend_next       = res_disp;
            pend_valid_next = 1'b1;
            n_disp_next     = n_disp + 4'd1;
          end
          if (idx == IDX_W'(TABLE_DEPTH - 1)) begin
            state_next = S_FLUSH;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (pend_valid) begin
            out_res_next      = pend;
            out_res_next.last = 1'b1;
          end else begin
            out_res_next        = '0;
            out_res_next.status = ST_NONE;
            out_res_next.last   = 1'b1;
            out_res_next.tick   = tick;
            out_res_next.count  = count_ext[3:0];
          end
          out_valid_next  = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      n_disp     <= 4'd0;
      count      <= '0;
      tick       <= 32'd0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      n_disp     <= n_disp_next;
      count      <= count_next;
      tick       <= tick_next;
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_res <= out_res_next;
    pend    <= pend_next;
  end

  assign status    = out_res.status;
  assign out_slot  = out_res.slot;
  assign out_tag   = out_res.tag;
  assign last      = out_res.last;
  assign tick_now  = out_res.tick;
  assign count_now = out_res.count;

endmodule
`default_nettype wire

/* src/ptd_cell.sv */
// One table entry of the task chain: hold, take the neighbour's entry, load or set enable.
`default_nettype none
module ptd_cell
  import ptd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     load_data,
  input  wire entry_t     nb_in,
  output entry_t          q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      priority if (ctrl.shift) begin
        q <= nb_in;
      end else if (ctrl.load) begin
        q <= load_data;
      end else if (ctrl.set_en) begin
        q.en <= ctrl.en_val;
      end
    end
  end

endmodule
`default_nettype wire

/* src/ptd_head.sv */
// Due test and reschedule of the entry at the head of the chain.
`default_nettype none
module ptd_head
  import ptd_pkg::*;
(
  input  wire entry_t      head,
  input  wire logic [31:0] tick,
  input  wire logic        active,
  output logic             due,
  output entry_t           upd
);

  logic [31:0] diff;

  always_comb begin
    diff = tick - head.next_run;
    due  = active && head.en && (head.tag != 8'd0) && !diff[31];
    upd  = head;
    if (due) begin
      upd.next_run = tick + head.period;
    end
  end

endmodule
`default_nettype wire

/* tb/periodic_task_dispatcher_tb.sv */
// Periodic task dispatcher testbench: directed commands, then random ones, checked by typed rows or a local predictor.
`timescale 1ns / 100ps
module periodic_task_dispatcher_tb;
  import ptd_pkg::*;

  localparam int DEPTH        = 8;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_SLACK  = 20;

  // Command codes the block does not use: each gives a plain done result
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  tag;
    logic [31:0] per;
    logic [31:0] offs;
    logic [2:0]  sl;
    logic        en;
  } cmd_item_t;

  typedef struct packed {
    cmd_item_t item;
    logic      typed;
    result_t   want;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd = '0;
  logic [7:0]  task_tag = '0;
  logic [31:0] period = '0;
  logic [31:0] start_offset = '0;
  logic [2:0]  slot = '0;
  logic        enable_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [2:0]  out_slot;
  logic [7:0]  out_tag;
  logic        last;
  logic [31:0] tick_now;
  logic [3:0]  count_now;

  // Mirror of the task table
  logic [7:0]  tbl_tag [DEPTH];
  logic [31:0] tbl_period [DEPTH];
  logic [31:0] tbl_next [DEPTH];
  logic        tbl_en [DEPTH];
  int          tbl_count;
  logic [31:0] tick_cnt;

  result_t  results_owed[$];
  cmd_row_t directed_rows[$];
  int       errors = 0;
  int       burst_left = 0;
  logic [8:0] stall_phase = '0;

  periodic_task_dispatcher u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .task_tag(task_tag), .period(period), .start_offset(start_offset),
    .slot(slot), .enable_flag(enable_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_slot(out_slot), .out_tag(out_tag), .last(last),
    .tick_now(tick_now), .count_now(count_now)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("periodic_task_dispatcher_tb: FAIL");
    $finish;
  end

  // Work out the results of one accepted command and advance the mirror
  task automatic apply_command(input cmd_item_t c);
    result_t r;
    result_t held;
    logic    have_held;
    logic [31:0] now;
    logic [31:0] lag;
    int i;
    int n;
    r = '0;
    r.last = 1'b1;
    r.status = ST_DONE;
    have_held = 1'b0;
    held = '0;
    n = 0;
    case (c.op)
      CMD_TICK: tick_cnt = tick_cnt + 32'd1;
      CMD_ADD: begin
        if (tbl_count >= DEPTH || c.tag == 8'd0) begin
          r.status = ST_REJECT;
        end else begin
          tbl_tag[tbl_count] = c.tag;
          tbl_period[tbl_count] = c.per;
          tbl_next[tbl_count] = tick_cnt + c.offs;
          tbl_en[tbl_count] = 1'b1;
          r.slot = tbl_count[2:0];
          tbl_count = tbl_count + 1;
        end
      end
      CMD_REMOVE: begin
        if (int'(c.sl) >= tbl_count) begin
          r.status = ST_BADSLOT;
        end else begin
          for (i = int'(c.sl); i + 1 < tbl_count; i++) begin
            tbl_tag[i] = tbl_tag[i + 1];
            tbl_period[i] = tbl_period[i + 1];
            tbl_next[i] = tbl_next[i + 1];
            tbl_en[i] = tbl_en[i + 1];
          end
          tbl_count = tbl_count - 1;
          tbl_tag[tbl_count] = '0;
          tbl_period[tbl_count] = '0;
          tbl_next[tbl_count] = '0;
          tbl_en[tbl_count] = 1'b0;
        end
      end
      CMD_ENABLE: begin
        if (int'(c.sl) >= tbl_count) r.status = ST_BADSLOT;
        else tbl_en[c.sl] = c.en;
      end
      CMD_RUN: begin
        now = tick_cnt;
        for (i = 0; i < tbl_count && n < MAX_RESULTS; i++) begin
          lag = now - tbl_next[i];
          if (tbl_en[i] && tbl_tag[i] != 8'd0 && !lag[31]) begin
            tbl_next[i] = now + tbl_period[i];
            // hold each dispatch back one step so the final one can carry last
            if (have_held) results_owed.push_back(held);
            held = '0;
            held.status = ST_DISPATCH;
            held.slot = i[2:0];
            held.tag = tbl_tag[i];
            held.tick = tick_cnt;
            held.count = tbl_count[3:0];
            have_held = 1'b1;
            n++;
          end
        end
        if (n == 0) r.status = ST_NONE;
      end
      default: ;
    endcase
    if (have_held) begin
      held.last = 1'b1;
      results_owed.push_back(held);
    end else begin
      r.tick = tick_cnt;
      r.count = tbl_count[3:0];
      results_owed.push_back(r);
    end
  endtask

  function automatic void add_row(input logic [2:0] op, input logic [7:0] tag,
                                  input logic [31:0] per, input logic [31:0] offs,
                                  input logic [2:0] sl, input logic en, input logic typed,
                                  input logic [2:0] st, input logic [2:0] oslot,
                                  input logic [7:0] otag, input logic [31:0] tk,
                                  input logic [3:0] cnt);
    cmd_row_t row;
    row.item.op = op;
    row.item.tag = tag;
    row.item.per = per;
    row.item.offs = offs;
    row.item.sl = sl;
    row.item.en = en;
    row.typed = typed;
    row.want.status = st;
    row.want.slot = oslot;
    row.want.tag = otag;
    row.want.last = 1'b1;
    row.want.tick = tk;
    row.want.count = cnt;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [31:0] pick_span(input int small_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, small_max);
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [2:0] pick_slot();
    if (tbl_count > 0 && $urandom_range(0, 99) < 85) return 3'($urandom_range(0, tbl_count - 1));
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t c;
    int r;
    c.tag = 8'($urandom_range(1, 255));
    c.per = pick_span(12);
    c.offs = pick_span(15);
    c.sl = pick_slot();
    c.en = ($urandom_range(0, 99) < 70);
    r = $urandom_range(0, 99);
    if (r < 30) c.op = CMD_TICK;
    else if (r < 48) begin
      c.op = CMD_ADD;
      if ($urandom_range(0, 19) == 0) c.tag = 8'd0;
    end
    else if (r < 62) c.op = CMD_REMOVE;
    else if (r < 72) c.op = CMD_ENABLE;
    else if (r < 97) c.op = CMD_RUN;
    else c.op = CMD_SPARE_FIRST + 3'($urandom_range(0, 2));
    return c;
  endfunction

  // Present one item in a burst, or after a random gap, and hold it until taken
  task automatic send(input cmd_item_t c);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
    in_valid <= 1'b1;
    cmd <= c.op;
    task_tag <= c.tag;
    period <= c.per;
    start_offset <= c.offs;
    slot <= c.sl;
    enable_flag <= c.en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (results_owed.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_out
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_owed.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d slot %0d tag %0h",
                 $time, status, out_slot, out_tag);
        errors++;
      end else begin
        want = results_owed.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("out_slot", 32'(want.slot), 32'(out_slot));
        compare_field("out_tag", 32'(want.tag), 32'(out_tag));
        compare_field("last", 32'(want.last), 32'(last));
        compare_field("tick_now", want.tick, tick_now);
        compare_field("count_now", 32'(want.count), 32'(count_now));
      end
    end
  end

  // Receiver: cycle through always ready, coin flips, a sparse pattern and mostly ready
  always @(posedge clk) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (stall_phase[1:0] == 2'b11);
      default: out_ready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  initial begin
    cmd_row_t row;
    int i;
    for (i = 0; i < DEPTH; i++) begin
      tbl_tag[i] = '0;
      tbl_period[i] = '0;
      tbl_next[i] = '0;
      tbl_en[i] = 1'b0;
    end
    tbl_count = 0;
    tick_cnt = '0;

    // op, tag, period, offset, slot, en, typed, status, slot, tag, tick, count
    add_row(CMD_RUN, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b1, ST_NONE, 3'd0, 8'd0, 32'd0, 4'd0);
    add_row(CMD_REMOVE, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b1, ST_BADSLOT, 3'd0, 8'd0, 32'd0,
            4'd0);
    add_row(CMD_ENABLE, 8'd0, 32'd0, 32'd0, 3'd7, 1'b1, 1'b1, ST_BADSLOT, 3'd0, 8'd0, 32'd0,
            4'd0);
    add_row(CMD_ADD, 8'd0, 32'd5, 32'd0, 3'd0, 1'b0, 1'b1, ST_REJECT, 3'd0, 8'd0, 32'd0, 4'd0);
    add_row(CMD_ADD, 8'hFF, 32'd0, 32'd0, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd0, 8'd0, 32'd0, 4'd1);
    add_row(CMD_RUN, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b0, ST_DONE, 3'd0, 8'd0, 32'd0, 4'd0);
    add_row(CMD_SPARE_FIRST, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, ST_DONE,
            3'd0, 8'd0, 32'd0, 4'd1);
    add_row(CMD_SPARE_MID, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd0, 8'd0, 32'd0,
            4'd1);
    add_row(CMD_SPARE_LAST, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd0, 8'd0, 32'd0,
            4'd1);
    add_row(CMD_ADD, 8'h01, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd1, 8'd0,
            32'd0, 4'd2);
    add_row(CMD_ADD, 8'h80, 32'h8000_0000, 32'h7FFF_FFFF, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd2, 8'd0,
            32'd0, 4'd3);
    add_row(CMD_ADD, 8'h55, 32'd3, 32'h8000_0000, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd3, 8'd0, 32'd0,
            4'd4);
    add_row(CMD_ADD, 8'hAA, 32'h7FFF_FFFF, 32'd2, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd4, 8'd0, 32'd0,
            4'd5);
    add_row(CMD_RUN, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b0, ST_DONE, 3'd0, 8'd0, 32'd0, 4'd0);
    add_row(CMD_TICK, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd0, 8'd0, 32'd1, 4'd5);
    add_row(CMD_ADD, 8'h02, 32'd1, 32'd0, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd5, 8'd0, 32'd1, 4'd6);
    add_row(CMD_ADD, 8'h03, 32'd2, 32'd1, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd6, 8'd0, 32'd1, 4'd7);
    add_row(CMD_ADD, 8'h04, 32'd0, 32'd0, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd7, 8'd0, 32'd1, 4'd8);
    add_row(CMD_ADD, 8'h05, 32'd1, 32'd0, 3'd0, 1'b0, 1'b1, ST_REJECT, 3'd0, 8'd0, 32'd1, 4'd8);
    add_row(CMD_ENABLE, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd0, 8'd0, 32'd1, 4'd8);
    add_row(CMD_RUN, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b0, ST_DONE, 3'd0, 8'd0, 32'd0, 4'd0);
    add_row(CMD_REMOVE, 8'd0, 32'd0, 32'd0, 3'd7, 1'b0, 1'b1, ST_DONE, 3'd0, 8'd0, 32'd1, 4'd7);
    add_row(CMD_REMOVE, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b1, ST_DONE, 3'd0, 8'd0, 32'd1, 4'd6);
    add_row(CMD_ENABLE, 8'd0, 32'd0, 32'd0, 3'd6, 1'b1, 1'b1, ST_BADSLOT, 3'd0, 8'd0, 32'd1,
            4'd6);
    add_row(CMD_TICK, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b0, ST_DONE, 3'd0, 8'd0, 32'd0, 4'd0);
    add_row(CMD_RUN, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, 1'b0, ST_DONE, 3'd0, 8'd0, 32'd0, 4'd0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      send(row.item);
      apply_command(row.item);
      // typed rows give one result: swap the predicted one for the typed value
      if (row.typed) begin
        void'(results_owed.pop_back());
        results_owed.push_back(row.want);
      end
    end
    wait_drain();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      row.item = random_item();
      send(row.item);
      apply_command(row.item);
      if (i == RANDOM_ITEMS / 2) wait_drain();
    end
    wait_drain();

    if (errors == 0) begin
      $display("periodic_task_dispatcher_tb: PASS");
    end else begin
      $display("periodic_task_dispatcher_tb: FAIL");
    end
    $finish;
  end

endmodule
